// ----- src/encoder_butterworth_state_estimator_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the encoder state estimator
// Clocked property wrappers shared by the port checker.
// ----------------------------------------------------------------------------
`ifndef ENCODER_BUTTERWORTH_STATE_ESTIMATOR_TOP_ASSERT_SVH
`define ENCODER_BUTTERWORTH_STATE_ESTIMATOR_TOP_ASSERT_SVH

// Check on every rising edge outside of reset
`define EBSE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ebse port check failed");

// Check on every rising edge, reset included
`define EBSE_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("ebse reset check failed");

`endif

// ----- src/ebse_pkg.sv -----
// ----------------------------------------------------------------------------
// ebse_pkg
// Types, constants and helpers of the encoder state estimator.
// ----------------------------------------------------------------------------
package ebse_pkg;

  localparam int NUM_JOINTS = 16;
  localparam int JOINT_W    = 4;
  localparam int HIST_W     = 3 * 32;

  localparam int CMD_DEPTH  = 2;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK_SQUARE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK_ADAPTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK_DEFAULT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIANS_PER_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_SECOND  = 3'd4;

  localparam logic [15:0] SPS_RESET = 16'd1000;

  localparam logic [1:0] STYLE_SQUARE  = 2'd0;
  localparam logic [1:0] STYLE_ADAPTER = 2'd1;

  // Butterworth coefficients, Q2.22
  localparam logic signed [23:0] CB0 = 24'sd120125;
  localparam logic signed [23:0] CB1 = 24'sd360333;
  localparam logic signed [23:0] CA1 = 24'sd6370728;
  localparam logic signed [23:0] CA2 = -24'sd4026532;
  localparam logic signed [23:0] CA3 = 24'sd889192;

  localparam logic [2:0] TAP_LAST = 3'd6;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_LOAD   = 1'b1
  } ebse_mode_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_LOAD   = 1'b1
  } ebse_cmd_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ACC,
    BK_RND,
    BK_VEL,
    BK_DONE
  } ebse_bk_state_e;

  typedef struct packed {
    ebse_cmd_e          kind;
    logic [JOINT_W-1:0] joint;
    logic signed [31:0] value;
  } ebse_cmd_t;

  typedef struct packed {
    logic [15:0] mask_square;
    logic [15:0] mask_adapter;
    logic [15:0] mask_default;
    logic [31:0] rad_per_count;
    logic [15:0] samples_per_sec;
  } ebse_cfg_t;

  // Tap order: x, x1, x2, x3, y1, y2, y3
  function automatic logic signed [23:0] ebse_coef(logic [2:0] tap);
    logic signed [23:0] c;
    unique case (tap)
      3'd0:    c = CB0;
      3'd1:    c = CB1;
      3'd2:    c = CB1;
      3'd3:    c = CB0;
      3'd4:    c = CA1;
      3'd5:    c = CA2;
      3'd6:    c = CA3;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] ebse_sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- src/ebse_front.sv -----
// ----------------------------------------------------------------------------
// ebse_front
// Accepts items, classifies them and turns encoder counts into Q12.20 angles.
// ----------------------------------------------------------------------------
module ebse_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_push_i,
  output logic                              in_full_o,
  input  logic                              mode_i,
  input  logic [ebse_pkg::JOINT_W-1:0]      joint_index_i,
  input  logic signed [31:0]                encoder_count_i,
  input  logic signed [31:0]                encoder_offset_i,
  input  logic [1:0]                        tool_style_i,
  input  logic signed [31:0]                reset_position_i,
  input  ebse_pkg::ebse_cfg_t               cfg_i,
  output ebse_pkg::ebse_cmd_t               cmd_o,
  output logic                              cmd_push_o,
  input  logic                              cmd_full_i
);
  import ebse_pkg::*;

  logic en;

  // stage A: registered item
  logic                     a_v_q;
  logic                     a_mode_q;
  logic [JOINT_W-1:0]       a_joint_q;
  logic signed [31:0]       a_count_q;
  logic signed [31:0]       a_offset_q;
  logic [1:0]               a_style_q;
  logic signed [31:0]       a_rpos_q;

  logic [15:0]              a_mask;
  logic                     a_inv;
  logic                     a_in_range;
  logic signed [32:0]       a_cnt;
  logic signed [32:0]       a_cnt_s;
  logic signed [33:0]       a_diff;
  logic [33:0]              a_mag;

  // stage B: magnitude times scale
  logic                     b_v_q;
  ebse_cmd_e                b_kind_q;
  logic [JOINT_W-1:0]       b_joint_q;
  logic                     b_neg_q;
  logic [33:0]              b_mag_q;
  logic signed [31:0]       b_rpos_q;
  logic [49:0]              b_phi;
  logic [50:0]              b_plo;

  // stage C: combine, round and saturate
  logic                     c_v_q;
  ebse_cmd_e                c_kind_q;
  logic [JOINT_W-1:0]       c_joint_q;
  logic                     c_neg_q;
  logic [49:0]              c_phi_q;
  logic [50:0]              c_plo_q;
  logic signed [31:0]       c_rpos_q;
  logic [54:0]              c_sum;
  logic signed [31:0]       c_pos;

  // stall the whole pipe while the last stage cannot hand off
  assign en        = !(c_v_q && cmd_full_i);
  assign in_full_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_push_i;
      b_v_q <= a_v_q && a_in_range;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mode_q   <= mode_i;
      a_joint_q  <= joint_index_i;
      a_count_q  <= encoder_count_i;
      a_offset_q <= encoder_offset_i;
      a_style_q  <= tool_style_i;
      a_rpos_q   <= reset_position_i;

      b_kind_q  <= (a_mode_q == MODE_LOAD) ? CMD_LOAD : CMD_SAMPLE;
      b_joint_q <= a_joint_q;
      b_neg_q   <= a_diff[33];
      b_mag_q   <= a_mag;
      b_rpos_q  <= a_rpos_q;

      c_kind_q  <= b_kind_q;
      c_joint_q <= b_joint_q;
      c_neg_q   <= b_neg_q;
      c_phi_q   <= b_phi;
      c_plo_q   <= b_plo;
      c_rpos_q  <= b_rpos_q;
    end
  end

  always_comb begin
    case (a_style_q)
      STYLE_SQUARE:  a_mask = cfg_i.mask_square;
      STYLE_ADAPTER: a_mask = cfg_i.mask_adapter;
      default:       a_mask = cfg_i.mask_default;
    endcase
    a_inv      = a_mask[a_joint_q];
    a_in_range = int'(a_joint_q) < NUM_JOINTS;
    a_cnt      = 33'(a_count_q);
    a_cnt_s    = a_inv ? -a_cnt : a_cnt;
    a_diff     = 34'(a_cnt_s) - 34'(a_offset_q);
    a_mag      = a_diff[33] ? 34'(-a_diff) : 34'(a_diff);
  end

  assign b_phi = b_mag_q * cfg_i.rad_per_count[31:16];
  assign b_plo = 51'(b_mag_q) * 51'(cfg_i.rad_per_count[15:0]) + 51'd2048;

  always_comb begin
    c_sum = {1'b0, c_phi_q, 4'b0000} + 55'(c_plo_q[50:12]);
    if (c_neg_q) begin
      c_pos = (c_sum >= 55'h80000000) ? 32'sh80000000 : 32'(-c_sum);
    end else begin
      c_pos = (c_sum > 55'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(c_sum);
    end
  end

  assign cmd_o.kind  = c_kind_q;
  assign cmd_o.joint = c_joint_q;
  assign cmd_o.value = (c_kind_q == CMD_LOAD) ? c_rpos_q : c_pos;
  assign cmd_push_o  = c_v_q && !cmd_full_i;

endmodule

// ----- src/ebse_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// ebse_cmd_queue
// Short command queue between the front end and the filter back end.
// ----------------------------------------------------------------------------
module ebse_cmd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ebse_pkg::ebse_cmd_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output ebse_pkg::ebse_cmd_t data_o,
  output logic                empty_o
);
  import ebse_pkg::*;

  ebse_cmd_t            slot_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q;
  logic [CMD_PTR_W-1:0] rd_ptr_q;
  logic [CMD_PTR_W:0]   count_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = count_q == (CMD_PTR_W + 1)'(CMD_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- src/ebse_back.sv -----
// ----------------------------------------------------------------------------
// ebse_back
// Per-joint third-order filter on one shared multiplier, velocity, result reg.
// ----------------------------------------------------------------------------
module ebse_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ebse_pkg::ebse_cmd_t           cmd_i,
  input  logic                          cmd_empty_i,
  output logic                          cmd_pop_o,
  input  ebse_pkg::ebse_cfg_t           cfg_i,
  input  logic                          res_pop_i,
  output logic                          res_empty_o,
  output logic [ebse_pkg::JOINT_W-1:0]  joint_o,
  output logic signed [31:0]            pos_o,
  output logic signed [31:0]            vel_o
);
  import ebse_pkg::*;

  ebse_bk_state_e state_q, state_d;
  logic [2:0]     tap_q, tap_d;

  // history rows: [31:0] newest, [95:64] oldest
  logic [HIST_W-1:0] xmem [NUM_JOINTS];
  logic [HIST_W-1:0] ymem [NUM_JOINTS];
  logic [HIST_W-1:0] xrd_q, yrd_q;
  logic [HIST_W-1:0] hx, hy;

  logic [NUM_JOINTS-1:0] ready_q;

  logic [JOINT_W-1:0]  joint_q;
  logic signed [31:0]  pos_q;
  logic                seed_q;
  logic signed [55:0]  prod_q;
  logic signed [59:0]  acc_q;
  logic signed [31:0]  filt_q;
  logic signed [49:0]  vprod_q;

  logic signed [31:0]  op;
  logic signed [59:0]  acc_rnd;
  logic signed [32:0]  vdiff;
  logic signed [49:0]  vel_rnd;

  logic                rd_en;
  logic                wr_en;
  logic [JOINT_W-1:0]  wr_addr;
  logic [HIST_W-1:0]   x_wdata;
  logic [HIST_W-1:0]   y_wdata;
  logic                res_load;

  logic                res_v_q;
  logic [JOINT_W-1:0]  res_joint_q;
  logic signed [31:0]  res_pos_q;
  logic signed [31:0]  res_vel_q;

  // a joint not yet ready reads its whole history as the current angle
  assign hx = seed_q ? {3{pos_q}} : xrd_q;
  assign hy = seed_q ? {3{pos_q}} : yrd_q;

  always_comb begin
    unique case (tap_q)
      3'd0:    op = pos_q;
      3'd1:    op = hx[31:0];
      3'd2:    op = hx[63:32];
      3'd3:    op = hx[95:64];
      3'd4:    op = hy[31:0];
      3'd5:    op = hy[63:32];
      3'd6:    op = hy[95:64];
      default: op = '0;
    endcase
  end

  assign acc_rnd = (acc_q + 60'sd2097152) >>> 22;
  assign vdiff   = 33'(filt_q) - 33'($signed(hy[31:0]));
  assign vel_rnd = (vprod_q + 50'sd8) >>> 4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      tap_q   <= '0;
      ready_q <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      if (res_load) begin
        ready_q[joint_q] <= 1'b1;
        res_v_q          <= 1'b1;
      end else if (res_pop_i) begin
        res_v_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    tap_d     = tap_q;
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = joint_q;
    x_wdata   = {hx[63:0], pos_q};
    y_wdata   = {hy[63:0], filt_q};
    res_load  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == CMD_LOAD) begin
            wr_en   = 1'b1;
            wr_addr = cmd_i.joint;
            x_wdata = {3{cmd_i.value}};
            y_wdata = {3{cmd_i.value}};
          end else begin
            rd_en   = 1'b1;
            tap_d   = '0;
            state_d = BK_MUL;
          end
        end
      end
      BK_MUL: begin
        tap_d = tap_q + 3'd1;
        if (tap_q == TAP_LAST) begin
          state_d = BK_ACC;
        end
      end
      BK_ACC: state_d = BK_RND;
      BK_RND: state_d = BK_VEL;
      BK_VEL: state_d = BK_DONE;
      BK_DONE: begin
        // hold until the result register frees up
        if (!res_v_q || res_pop_i) begin
          wr_en    = 1'b1;
          res_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      xmem[wr_addr] <= x_wdata;
      ymem[wr_addr] <= y_wdata;
    end
    if (rd_en) begin
      xrd_q <= xmem[cmd_i.joint];
      yrd_q <= ymem[cmd_i.joint];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      joint_q <= cmd_i.joint;
      pos_q   <= cmd_i.value;
      seed_q  <= !ready_q[cmd_i.joint];
    end
    if (state_q == BK_MUL) begin
      prod_q <= op * ebse_coef(tap_q);
      acc_q  <= (tap_q == '0) ? '0 : acc_q + 60'(prod_q);
    end
    if (state_q == BK_ACC) begin
      acc_q <= acc_q + 60'(prod_q);
    end
    if (state_q == BK_RND) begin
      filt_q <= ebse_sat32(64'(acc_rnd));
    end
    if (state_q == BK_VEL) begin
      vprod_q <= vdiff * $signed({1'b0, cfg_i.samples_per_sec});
    end
    if (res_load) begin
      res_joint_q <= joint_q;
      res_pos_q   <= filt_q;
      res_vel_q   <= ebse_sat32(64'(vel_rnd));
    end
  end

  assign res_empty_o = !res_v_q;
  assign joint_o     = res_joint_q;
  assign pos_o       = res_pos_q;
  assign vel_o       = res_vel_q;

endmodule

// ----- src/encoder_butterworth_state_estimator_top.sv -----
// ----------------------------------------------------------------------------
// encoder_butterworth_state_estimator_top
// Back end takes sample items one at a time through the seven-tap MAC on
//   its one shared filter multiplier; a history load is written from idle.
// Reset: async active low; clears queues, filter-ready bits and config
//   (sample rate 1000); filter histories are undefined until written.
// ----------------------------------------------------------------------------
module encoder_butterworth_state_estimator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                mode_i,
  input  logic [ebse_pkg::JOINT_W-1:0]        joint_index_i,
  input  logic signed [31:0]                  encoder_count_i,
  input  logic signed [31:0]                  encoder_offset_i,
  input  logic [1:0]                          tool_style_i,
  input  logic signed [31:0]                  reset_position_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [ebse_pkg::JOINT_W-1:0]        joint_index_out_o,
  output logic signed [31:0]                  motor_position_o,
  output logic signed [31:0]                  motor_velocity_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ebse_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [31:0]                         cfg_data_i
);
  import ebse_pkg::*;

  ebse_cfg_t cfg_q;
  ebse_cmd_t front_cmd;
  ebse_cmd_t queue_cmd;
  logic      cmd_push;
  logic      cmd_full;
  logic      cmd_pop;
  logic      cmd_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask_square     <= '0;
      cfg_q.mask_adapter    <= '0;
      cfg_q.mask_default    <= '0;
      cfg_q.rad_per_count   <= '0;
      cfg_q.samples_per_sec <= SPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_INVERT_MASK_SQUARE:  cfg_q.mask_square     <= cfg_data_i[15:0];
        CFG_INVERT_MASK_ADAPTER: cfg_q.mask_adapter    <= cfg_data_i[15:0];
        CFG_INVERT_MASK_DEFAULT: cfg_q.mask_default    <= cfg_data_i[15:0];
        CFG_RADIANS_PER_COUNT:   cfg_q.rad_per_count   <= cfg_data_i;
        CFG_SAMPLES_PER_SECOND:  cfg_q.samples_per_sec <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  ebse_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_push_i        (push),
    .in_full_o        (full),
    .mode_i           (mode_i),
    .joint_index_i    (joint_index_i),
    .encoder_count_i  (encoder_count_i),
    .encoder_offset_i (encoder_offset_i),
    .tool_style_i     (tool_style_i),
    .reset_position_i (reset_position_i),
    .cfg_i            (cfg_q),
    .cmd_o            (front_cmd),
    .cmd_push_o       (cmd_push),
    .cmd_full_i       (cmd_full)
  );

  ebse_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (queue_cmd),
    .empty_o (cmd_empty)
  );

  ebse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg_q),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .joint_o     (joint_index_out_o),
    .pos_o       (motor_position_o),
    .vel_o       (motor_velocity_o)
  );

endmodule

// ----- src/ebse_port_checker.sv -----
// ----------------------------------------------------------------------------
// ebse_port_checker
// Port-level checks on the estimator, bound to the top level.
// ----------------------------------------------------------------------------
`include "encoder_butterworth_state_estimator_top_assert.svh"

module ebse_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic                           cfg_ready_o,
  input logic [ebse_pkg::JOINT_W-1:0]   joint_index_out_o,
  input logic signed [31:0]             motor_position_o,
  input logic signed [31:0]             motor_velocity_o
);

  // no result shows while in reset
  `EBSE_ASSERT_RST(a_empty_in_reset, !rst_ni |-> empty)

  // the pipe comes out of reset able to take an item
  `EBSE_ASSERT(a_open_after_reset, $past(!rst_ni) |-> !full)

  // config writes are never held off
  `EBSE_ASSERT(a_cfg_always_ready, cfg_ready_o)

  // a waiting result holds until taken
  `EBSE_ASSERT(a_result_holds, !empty && !pop |=> !empty && $stable(joint_index_out_o) && $stable(motor_position_o) && $stable(motor_velocity_o))

  // a result leaves only by being taken
  `EBSE_ASSERT(a_result_not_dropped, $rose(empty) |-> $past(pop))

endmodule

bind encoder_butterworth_state_estimator_top ebse_port_checker u_port_checker (.*);

// ----- dv/tb_encoder_butterworth_state_estimator_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_encoder_butterworth_state_estimator_top
// Drives encoder samples and history loads into the state estimator through
// its queue ports. A scoreboard predicts the filtered position and velocity
// of every joint and compares each popped result, field by field.
// ----------------------------------------------------------------------------
module tb_encoder_butterworth_state_estimator_top;
  import ebse_pkg::*;

  localparam int  JOINTS          = 16;
  localparam int  ITEMS_PER_PHASE = 296;
  localparam int  SETTLE_CYCLES   = 50;

  localparam logic [1:0] STYLE_OTHER = 2'd2;
  localparam logic [1:0] STYLE_SPARE = 2'd3;

  // Butterworth taps, Q2.22
  localparam longint TAP_B0 = 120125;
  localparam longint TAP_B1 = 360333;
  localparam longint TAP_A1 = 6370728;
  localparam longint TAP_A2 = -4026532;
  localparam longint TAP_A3 = 889192;

  typedef struct {
    ebse_mode_e         mode;
    logic [JOINT_W-1:0] joint;
    logic signed [31:0] count;
    logic signed [31:0] offset;
    logic [1:0]         style;
    logic signed [31:0] home;
  } enc_item_t;

  typedef struct {
    logic [JOINT_W-1:0] joint;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } motor_state_t;

  class ebse_scoreboard;
    logic [15:0]        mask_square;
    logic [15:0]        mask_adapter;
    logic [15:0]        mask_default;
    logic [31:0]        rad_per_count;
    logic [15:0]        rate;
    logic signed [31:0] x_hist [JOINTS][3];
    logic signed [31:0] y_hist [JOINTS][3];
    bit                 seeded [JOINTS];
    motor_state_t       expected_states [$];
    int                 mismatches;

    function new();
      mask_square   = '0;
      mask_adapter  = '0;
      mask_default  = '0;
      rad_per_count = '0;
      rate          = SPS_RESET;
      mismatches    = 0;
      foreach (seeded[j]) seeded[j] = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_INVERT_MASK_SQUARE:  mask_square   = data[15:0];
        CFG_INVERT_MASK_ADAPTER: mask_adapter  = data[15:0];
        CFG_INVERT_MASK_DEFAULT: mask_default  = data[15:0];
        CFG_RADIANS_PER_COUNT:   rad_per_count = data;
        CFG_SAMPLES_PER_SECOND:  rate          = data[15:0];
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    // Count difference times Q0.32 scale, rounded half away from zero to Q12.20
    function logic signed [31:0] to_angle(longint diff);
      longint unsigned m;
      longint unsigned q;
      bit              neg;
      neg = diff < 0;
      m   = neg ? -diff : diff;
      q   = ((m * rad_per_count[31:16]) << 4) + ((m * rad_per_count[15:0] + 2048) >> 12);
      if (neg) return (q >= 64'h8000_0000) ? 32'sh80000000 : 32'(64'd0 - q);
      return (q > 64'h7FFF_FFFF) ? 32'sh7FFFFFFF : q[31:0];
    endfunction

    function void note_sample(enc_item_t it);
      logic [15:0]        mask;
      longint             c;
      longint             acc;
      longint             vel;
      logic signed [31:0] pos;
      logic signed [31:0] filt;
      motor_state_t       r;
      int                 j;
      j = int'(it.joint);
      if (it.mode == MODE_LOAD) begin
        for (int k = 0; k < 3; k++) begin
          x_hist[j][k] = it.home;
          y_hist[j][k] = it.home;
        end
        return;
      end
      case (it.style)
        STYLE_SQUARE:  mask = mask_square;
        STYLE_ADAPTER: mask = mask_adapter;
        default:       mask = mask_default;
      endcase
      c = longint'(it.count);
      if (mask[j]) c = -c;
      pos = to_angle(c - longint'(it.offset));
      // first sample of a joint: start the filter at steady state
      if (!seeded[j]) begin
        for (int k = 0; k < 3; k++) begin
          x_hist[j][k] = pos;
          y_hist[j][k] = pos;
        end
        seeded[j] = 1'b1;
      end
      acc = TAP_B0 * pos + TAP_B1 * x_hist[j][0] + TAP_B1 * x_hist[j][1]
          + TAP_B0 * x_hist[j][2] + TAP_A1 * y_hist[j][0] + TAP_A2 * y_hist[j][1]
          + TAP_A3 * y_hist[j][2];
      filt = clip32((acc + 64'sd2097152) >>> 22);
      vel  = (longint'(filt) - longint'(y_hist[j][0])) * longint'({48'd0, rate});
      vel  = (vel + 8) >>> 4;
      x_hist[j][2] = x_hist[j][1];
      x_hist[j][1] = x_hist[j][0];
      x_hist[j][0] = pos;
      y_hist[j][2] = y_hist[j][1];
      y_hist[j][1] = y_hist[j][0];
      y_hist[j][0] = filt;
      r.joint    = it.joint;
      r.position = filt;
      r.velocity = clip32(vel);
      expected_states.push_back(r);
    endfunction

    function void report(string what, longint exp_v, longint got_v);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
    endfunction

    function void check_state(motor_state_t got);
      motor_state_t e;
      if (expected_states.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual joint %0d pos %0d vel %0d",
                 $time, got.joint, got.position, got.velocity);
        return;
      end
      e = expected_states.pop_front();
      if (got.joint !== e.joint) report("joint", e.joint, got.joint);
      if (got.position !== e.position) report("position", e.position, got.position);
      if (got.velocity !== e.velocity) report("velocity", e.velocity, got.velocity);
    endfunction

    function int pending();
      return expected_states.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  ebse_mode_e           mode_i;
  logic [JOINT_W-1:0]   joint_index_i;
  logic signed [31:0]   encoder_count_i;
  logic signed [31:0]   encoder_offset_i;
  logic [1:0]           tool_style_i;
  logic signed [31:0]   reset_position_i;
  logic                 empty;
  logic                 pop;
  logic [JOINT_W-1:0]   joint_index_out_o;
  logic signed [31:0]   motor_position_o;
  logic signed [31:0]   motor_velocity_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  ebse_scoreboard sb = new();
  bit             gaps_on = 1'b1;
  int             walk_count  [JOINTS];
  int             walk_offset [JOINTS];

  encoder_butterworth_state_estimator_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .mode_i           (mode_i),
    .joint_index_i    (joint_index_i),
    .encoder_count_i  (encoder_count_i),
    .encoder_offset_i (encoder_offset_i),
    .tool_style_i     (tool_style_i),
    .reset_position_i (reset_position_i),
    .empty            (empty),
    .pop              (pop),
    .joint_index_out_o(joint_index_out_o),
    .motor_position_o (motor_position_o),
    .motor_velocity_o (motor_velocity_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic enc_item_t make_item(ebse_mode_e mode, int joint, logic [31:0] count,
                                          logic [31:0] offset, logic [1:0] style,
                                          logic [31:0] home);
    enc_item_t s;
    s.mode   = mode;
    s.joint  = joint[JOINT_W-1:0];
    s.count  = count;
    s.offset = offset;
    s.style  = style;
    s.home   = home;
    return s;
  endfunction

  // Mostly slow per-joint encoder walks so the filter tracks real motion,
  // mixed with history loads and fully random items.
  function automatic enc_item_t random_item();
    enc_item_t s;
    int        j;
    int        r;
    int        step;
    int        near;
    r    = $urandom_range(99);
    j    = $urandom_range(JOINTS - 1);
    step = $urandom_range(200);
    near = $urandom_range(8388608);
    s    = make_item(MODE_SAMPLE, j, walk_count[j], walk_offset[j],
                     2'($urandom_range(3)), $urandom);
    if (r < 65) begin
      walk_count[j] += step - 100;
      s.count = walk_count[j];
    end else if (r < 78) begin
      s.mode   = MODE_LOAD;
      s.count  = $urandom;
      s.offset = $urandom;
      if (r < 72) s.home = near - 4194304;
    end else begin
      s.mode   = ebse_mode_e'($urandom_range(1));
      s.count  = $urandom;
      s.offset = $urandom;
    end
    return s;
  endfunction

  task automatic push_item(input enc_item_t it);
    while (gaps_on && $urandom_range(99) < 33) begin
      @(negedge clk_i);
      push <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    push             <= 1'b1;
    mode_i           <= it.mode;
    joint_index_i    <= it.joint;
    encoder_count_i  <= it.count;
    encoder_offset_i <= it.offset;
    tool_style_i     <= it.style;
    reset_position_i <= it.home;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_sample(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop push, drain every expected result, then let trailing loads finish
  task automatic wait_idle();
    @(negedge clk_i);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] sq, input logic [15:0] ad,
                              input logic [15:0] df, input logic [31:0] rpc,
                              input logic [15:0] sps);
    write_reg(CFG_INVERT_MASK_SQUARE, {16'd0, sq});
    write_reg(CFG_INVERT_MASK_ADAPTER, {16'd0, ad});
    write_reg(CFG_INVERT_MASK_DEFAULT, {16'd0, df});
    write_reg(CFG_RADIANS_PER_COUNT, rpc);
    write_reg(CFG_SAMPLES_PER_SECOND, {16'd0, sps});
  endtask

  // Result side: pop at random, check at the rising edge
  initial begin
    motor_state_t got;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      pop <= (gaps_on && $urandom_range(99) < 33) ? 1'b0 : 1'b1;
      @(posedge clk_i);
      if (pop && !empty) begin
        got.joint    = joint_index_out_o;
        got.position = motor_position_o;
        got.velocity = motor_velocity_o;
        sb.check_state(got);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int tmp;
    rst_ni           = 1'b0;
    push             = 1'b0;
    mode_i           = MODE_SAMPLE;
    joint_index_i    = '0;
    encoder_count_i  = '0;
    encoder_offset_i = '0;
    tool_style_i     = STYLE_SQUARE;
    reset_position_i = '0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = CFG_INVERT_MASK_SQUARE;
    cfg_data_i       = '0;
    for (int j = 0; j < JOINTS; j++) begin
      tmp            = $urandom_range(2000);
      walk_offset[j] = tmp - 1000;
      walk_count[j]  = walk_offset[j];
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: seeding, saturation, inversion per style, loads
    program_regs(16'h00FF, 16'hF0F0, 16'h5555, 32'h0064_87ED, 16'd1000);
    push_item(make_item(MODE_SAMPLE, 0, 32'd0, 32'd0, STYLE_SQUARE, 32'd0));
    push_item(make_item(MODE_SAMPLE, 0, 32'd1000, -32'sd50, STYLE_ADAPTER, 32'd0));
    push_item(make_item(MODE_SAMPLE, 0, 32'd2000, -32'sd50, STYLE_OTHER, 32'd0));
    push_item(make_item(MODE_SAMPLE, 1, 32'h7FFF_FFFF, 32'h8000_0000, STYLE_OTHER, 32'd0));
    push_item(make_item(MODE_SAMPLE, 1, 32'h8000_0000, 32'h7FFF_FFFF, STYLE_SPARE, 32'd0));
    push_item(make_item(MODE_SAMPLE, 3, 32'h8000_0000, 32'd0, STYLE_SQUARE, 32'd0));
    push_item(make_item(MODE_SAMPLE, 3, 32'd0, 32'd0, STYLE_SQUARE, 32'd0));
    push_item(make_item(MODE_SAMPLE, 4, 32'd12345, 32'd0, STYLE_ADAPTER, 32'd0));
    push_item(make_item(MODE_LOAD, 0, 32'd0, 32'd0, STYLE_SQUARE, 32'h7FFF_FFFF));
    push_item(make_item(MODE_SAMPLE, 0, -32'sd100000, 32'd0, STYLE_SQUARE, 32'd0));
    push_item(make_item(MODE_LOAD, 2, 32'd0, 32'd0, STYLE_SQUARE, 32'h8000_0000));
    push_item(make_item(MODE_SAMPLE, 2, 32'd77, 32'd3, STYLE_ADAPTER, 32'd0));
    push_item(make_item(MODE_SAMPLE, 2, 32'd78, 32'd3, STYLE_ADAPTER, 32'd0));
    push_item(make_item(MODE_LOAD, 15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, STYLE_SPARE, 32'd0));
    push_item(make_item(MODE_SAMPLE, 15, 32'h7FFF_FFFF, 32'h7FFF_FFFF, STYLE_SQUARE, 32'd0));
    push_item(make_item(MODE_SAMPLE, 15, 32'hFFFF_FFFF, 32'd0, STYLE_SPARE, 32'd0));
    push_item(make_item(MODE_SAMPLE, 7, 32'd500, 32'd400, STYLE_OTHER, 32'd0));
    push_item(make_item(MODE_SAMPLE, 6, 32'd500, 32'd400, STYLE_OTHER, 32'd0));
    push_item(make_item(MODE_SAMPLE, 6, 32'd900, 32'd400, STYLE_OTHER, 32'd0));

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: program_regs(16'h0000, 16'h0000, 16'h0000, 32'd0, 16'd1);
        1: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        2: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 32'h0064_87ED,
                        16'd1000);
        // zero sample rate: velocity stays zero
        3: program_regs(16'($urandom), 16'($urandom), 16'($urandom), $urandom, 16'd0);
        default: program_regs(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                              16'($urandom_range(65535, 1)));
      endcase
      gaps_on = (ph != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) push_item(random_item());
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
